// File: rtl/lpts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpts_pkg
// Shared types, constants and helpers for the long-press toggle switch.
// ----------------------------------------------------------------------------
package lpts_pkg;

   localparam int CHANNELS   = 16;
   localparam int COUNT_BITS = 16;
   localparam int THR_BITS   = 16;
   localparam int THR_RESET  = 150;
   localparam int ROW_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // APB map
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;
   localparam logic REG_HOLD_THRESHOLD = 1'b0;   // paddr[2] word index

   typedef enum logic [1:0] {
      CMD_PASS    = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_HOLD    = 2'd2
   } cmd_type;

   // one memory row holds both mode groups of a channel
   typedef struct packed {
      logic                  rel_latch;
      logic [COUNT_BITS-1:0] rel_count;
      logic                  hold_latch;
      logic [COUNT_BITS-1:0] hold_count;
   } row_type;

   typedef struct packed {
      logic                rd_en;
      logic [ROW_BITS-1:0] rd_row;
      logic                wr_en;
      logic [ROW_BITS-1:0] wr_row;
      row_type             wr_data;
   } mem_cmd_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
   endfunction

endpackage
`default_nettype wire

// File: rtl/lpts_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpts_req_if
// Sample channel: command, channel number and raw switch level.
// ----------------------------------------------------------------------------
interface lpts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [3:0] channel;
   logic       pressed;

   modport source (output valid, output command, output channel, output pressed,
                   input ready);
   modport sink   (input valid, input command, input channel, input pressed,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/lpts_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpts_rsp_if
// Result channel: switch state and toggle flag.
// ----------------------------------------------------------------------------
interface lpts_rsp_if;
   logic valid;
   logic ready;
   logic switch_state;
   logic toggled;

   modport source (output valid, output switch_state, output toggled, input ready);
   modport sink   (input valid, input switch_state, input toggled, output ready);
endinterface
`default_nettype wire

// File: rtl/lpts_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpts_csr
// APB register file holding the hold threshold.
// ----------------------------------------------------------------------------
module lpts_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [lpts_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [lpts_pkg::DATA_BITS-1:0] pwdata,
   output logic      [lpts_pkg::DATA_BITS-1:0] prdata,
   output logic                                pready,
   output logic      [lpts_pkg::THR_BITS-1:0]  hold_threshold
);

   logic [lpts_pkg::THR_BITS-1:0] thr_ff;
   logic [lpts_pkg::THR_BITS-1:0] thr_in;
   logic                          hit;

   assign pready = 1'b1;
   assign hit    = (paddr[2] == lpts_pkg::REG_HOLD_THRESHOLD) && (paddr[1:0] == 2'b00);

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && hit) begin
         thr_in = pwdata[lpts_pkg::THR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= lpts_pkg::THR_BITS'(lpts_pkg::THR_RESET);
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign prdata = hit ? lpts_pkg::DATA_BITS'(thr_ff) : '0;
   assign hold_threshold = thr_ff;

endmodule
`default_nettype wire

// File: rtl/lpts_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpts_mem
// Per-channel state memory with registered read, valid bits and write forwarding.
// ----------------------------------------------------------------------------
module lpts_mem (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lpts_pkg::mem_cmd_type cmd,
   output lpts_pkg::row_type          rd_data
);

   lpts_pkg::row_type mem [lpts_pkg::CHANNELS];

   logic [lpts_pkg::CHANNELS-1:0] valid_ff;
   logic [lpts_pkg::CHANNELS-1:0] valid_in;
   lpts_pkg::row_type             rd_data_ff;
   logic                          rd_vld_ff;
   logic                          rd_vld_in;
   logic                          fwd_hit_ff;
   logic                          fwd_hit_in;
   lpts_pkg::row_type             fwd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_row] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff  <= mem[cmd.rd_row];
         fwd_data_ff <= cmd.wr_data;
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      rd_vld_in  = rd_vld_ff;
      fwd_hit_in = fwd_hit_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_row] = 1'b1;
      end
      if (cmd.rd_en) begin
         rd_vld_in  = valid_ff[cmd.rd_row];
         // read sees the old row when the same row is written at this edge
         fwd_hit_in = cmd.wr_en && (cmd.wr_row == cmd.rd_row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         rd_vld_ff  <= rd_vld_in;
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : (rd_vld_ff ? rd_data_ff : '0);

endmodule
`default_nettype wire

// File: rtl/lpts_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpts_core
// Two-stage pipeline: read the channel row, then update, write back and
// register the result.
// ----------------------------------------------------------------------------
module lpts_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lpts_pkg::THR_BITS-1:0] hold_threshold,
   lpts_req_if.sink                           req,
   lpts_rsp_if.source                         rsp,
   output lpts_pkg::mem_cmd_type              mem_cmd,
   input  wire lpts_pkg::row_type             rd_data
);

   logic adv;
   logic accept;

   // stage 1: item waiting for its row
   logic                          s1_valid_ff, s1_valid_in;
   lpts_pkg::cmd_type             s1_cmd_ff, s1_cmd_in;
   logic                          s1_hit_ff, s1_hit_in;
   logic                          s1_pressed_ff;
   logic [lpts_pkg::ROW_BITS-1:0] s1_row_ff;

   // output register
   logic out_valid_ff, out_valid_in;
   logic out_state_ff, out_state_in;
   logic out_toggled_ff, out_toggled_in;

   lpts_pkg::row_type               nrow;
   logic                            flip;
   logic [lpts_pkg::COUNT_BITS-1:0] cnt_inc;
   logic [lpts_pkg::CMP_BITS-1:0]   thr_x;

   assign adv       = !out_valid_ff || rsp.ready;
   assign accept    = req.valid && adv;
   assign req.ready = adv;

   always_comb begin
      case (lpts_pkg::cmd_type'(req.command))
         lpts_pkg::CMD_RELEASE: s1_cmd_in = lpts_pkg::CMD_RELEASE;
         lpts_pkg::CMD_HOLD:    s1_cmd_in = lpts_pkg::CMD_HOLD;
         default:               s1_cmd_in = lpts_pkg::CMD_PASS;
      endcase
      s1_hit_in   = 32'(req.channel) < lpts_pkg::CHANNELS;
      s1_valid_in = adv ? accept : s1_valid_ff;
   end

   // row update
   always_comb begin
      nrow    = rd_data;
      flip    = 1'b0;
      thr_x   = lpts_pkg::CMP_BITS'(hold_threshold);
      cnt_inc = '0;
      case (s1_cmd_ff)
         lpts_pkg::CMD_RELEASE: begin
            cnt_inc = lpts_pkg::sat_inc(rd_data.rel_count);
            if (s1_pressed_ff) begin
               nrow.rel_count = cnt_inc;
            end else begin
               flip           = lpts_pkg::CMP_BITS'(rd_data.rel_count) > thr_x;
               nrow.rel_latch = rd_data.rel_latch ^ flip;
               nrow.rel_count = '0;
            end
         end
         lpts_pkg::CMD_HOLD: begin
            cnt_inc = lpts_pkg::sat_inc(rd_data.hold_count);
            if (s1_pressed_ff) begin
               nrow.hold_count = cnt_inc;
               // single toggle on the sample that first crosses the threshold
               flip = (lpts_pkg::CMP_BITS'(rd_data.hold_count) <= thr_x) &&
                      (lpts_pkg::CMP_BITS'(cnt_inc) > thr_x);
               nrow.hold_latch = rd_data.hold_latch ^ flip;
            end else begin
               nrow.hold_count = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_state_in   = out_state_ff;
      out_toggled_in = out_toggled_ff;
      if (adv) begin
         out_valid_in = s1_valid_ff;
         case (s1_cmd_ff)
            lpts_pkg::CMD_RELEASE: begin
               out_state_in   = s1_hit_ff && nrow.rel_latch;
               out_toggled_in = s1_hit_ff && flip;
            end
            lpts_pkg::CMD_HOLD: begin
               out_state_in   = s1_hit_ff && nrow.hold_latch;
               out_toggled_in = s1_hit_ff && flip;
            end
            default: begin
               out_state_in   = s1_pressed_ff;
               out_toggled_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      mem_cmd.rd_en   = accept;
      mem_cmd.rd_row  = lpts_pkg::ROW_BITS'(req.channel);
      mem_cmd.wr_en   = adv && s1_valid_ff && s1_hit_ff && (s1_cmd_ff != lpts_pkg::CMD_PASS);
      mem_cmd.wr_row  = s1_row_ff;
      mem_cmd.wr_data = nrow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff     <= s1_cmd_in;
         s1_hit_ff     <= s1_hit_in;
         s1_pressed_ff <= req.pressed;
         s1_row_ff     <= lpts_pkg::ROW_BITS'(req.channel);
      end
      out_state_ff   <= out_state_in;
      out_toggled_ff <= out_toggled_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.switch_state = out_state_ff;
   assign rsp.toggled      = out_toggled_ff;

endmodule
`default_nettype wire

// File: rtl/long_press_toggle_switch_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// long_press_toggle_switch_top
// Per-channel long-press toggle switch with pass-through, release and hold modes.
// ----------------------------------------------------------------------------
//  port    dir   kind                 payload
//  req     in    valid/ready          command, channel, pressed
//  rsp     out   valid/ready          switch_state, toggled
//  APB     in    psel/penable/pready  hold_threshold at 0x0
//
//  One sample per cycle while rsp is not stalled; a req transfer passes through
//  stage 1 and then the output register, which drives rsp.valid.
//  The channel row is read from a registered-read memory and written back when
//  stage 1 advances; a back-to-back same-row sample is served by write forwarding.
//  Reset clears the row valid bits, so all latches and counts read as zero.
//  A stalled rsp holds the output register and pipeline and drops req.ready.
// ----------------------------------------------------------------------------
module long_press_toggle_switch_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   lpts_req_if.sink                            req,
   lpts_rsp_if.source                          rsp,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [lpts_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [lpts_pkg::DATA_BITS-1:0] pwdata,
   output logic      [lpts_pkg::DATA_BITS-1:0] prdata,
   output logic                                pready
);

   logic [lpts_pkg::THR_BITS-1:0] hold_threshold;
   lpts_pkg::mem_cmd_type         mem_cmd;
   lpts_pkg::row_type             rd_data;

   lpts_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .hold_threshold (hold_threshold)
   );

   lpts_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   lpts_core u_core (
      .clock          (clock),
      .reset          (reset),
      .hold_threshold (hold_threshold),
      .req            (req),
      .rsp            (rsp),
      .mem_cmd        (mem_cmd),
      .rd_data        (rd_data)
   );

`ifndef SYNTHESIS
   // write-back only when the pipeline moves
   a_wr_on_adv: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> (!rsp.valid || rsp.ready))
      else $error("state written while pipeline stalled");

   // same-row read during write-back must see the new row
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      (mem_cmd.rd_en && mem_cmd.wr_en && (mem_cmd.rd_row == mem_cmd.wr_row))
      |=> (rd_data == $past(mem_cmd.wr_data)))
      else $error("forwarded row mismatch");

   // a held result blocks new transfers
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("sample taken while result stalled");
`endif

endmodule
`default_nettype wire
